/* rtl/core/wcsa_pkg.sv */
// Shared types, constants and the sequencer program for the weighted capped share allocator.
// Used by weighted_capped_share_allocator, wcsa_port_checks, wcsa_checker and the testbench; depends on nothing else.
`default_nettype none

package wcsa_pkg;

   localparam int BUDGET_W = 32;
   localparam int SHARE_W  = 20;
   localparam int POOLS    = 5;
   localparam int POOL_W   = 3;
   localparam int LAST_POOL = POOLS - 1;
   localparam int STORE_POOL = 2;

   // scaled-case values stay below the sum of five caps
   localparam int ACC_W     = SHARE_W + 3;
   localparam int QUO_W     = ACC_W + (ACC_W % 2);
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int TW_W      = 4;
   localparam int WT_W      = 3;
   localparam int PROD_W    = QUO_W + WT_W;
   localparam int GROW_W    = PROD_W + 1;
   localparam int RND_W     = 4;
   localparam int MAX_ROUNDS = 8;

   localparam int CSR_IDX_W = 3;
   localparam int RSP_BITS  = 4 * SHARE_W + BUDGET_W + 2;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;
   localparam int REQ_W     = ((BUDGET_W + 7) / 8) * 8;

   // output field offsets in rsp_tdata
   localparam int F_CORE   = 0;
   localparam int F_ENGINE = F_CORE + SHARE_W;
   localparam int F_STORE  = F_ENGINE + SHARE_W;
   localparam int F_SYSTEM = F_STORE + BUDGET_W;
   localparam int F_USER   = F_SYSTEM + SHARE_W;
   localparam int F_OUTC   = F_USER + SHARE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_CORE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_ENGINE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_STORE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_SYSTEM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP_USER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_MIN   = 3'd5;

   localparam logic [SHARE_W-1:0] RST_CAP_CORE   = SHARE_W'(2000);
   localparam logic [SHARE_W-1:0] RST_CAP_ENGINE = SHARE_W'(30000);
   localparam logic [SHARE_W-1:0] RST_CAP_STORE  = SHARE_W'(2000);
   localparam logic [SHARE_W-1:0] RST_CAP_SYSTEM = SHARE_W'(5000);
   localparam logic [SHARE_W-1:0] RST_CAP_USER   = SHARE_W'(60000);
   localparam logic [SHARE_W-1:0] RST_POOL_MIN   = SHARE_W'(500);

   // outcome codes
   localparam logic [1:0] OUT_FULL   = 2'd0;
   localparam logic [1:0] OUT_SCALED = 2'd1;
   localparam logic [1:0] OUT_MIN    = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_WAIT    = 4'd0;
   localparam logic [3:0] OP_CAPSUM  = 4'd1;
   localparam logic [3:0] OP_NOP     = 4'd2;
   localparam logic [3:0] OP_MIN5    = 4'd3;
   localparam logic [3:0] OP_INIT    = 4'd4;
   localparam logic [3:0] OP_SPARE0  = 4'd5;
   localparam logic [3:0] OP_SPARE   = 4'd6;
   localparam logic [3:0] OP_DIVINIT = 4'd7;
   localparam logic [3:0] OP_DIV     = 4'd8;
   localparam logic [3:0] OP_GROW    = 4'd9;
   localparam logic [3:0] OP_NEXTRND = 4'd10;
   localparam logic [3:0] OP_LEFT    = 4'd11;
   localparam logic [3:0] OP_SETOUT  = 4'd12;
   localparam logic [3:0] OP_FULL    = 4'd13;
   localparam logic [3:0] OP_STORE   = 4'd14;
   localparam logic [3:0] OP_EMIT    = 4'd15;

   // jump conditions
   localparam logic [3:0] CND_NONE   = 4'd0;
   localparam logic [3:0] CND_ALWAYS = 4'd1;
   localparam logic [3:0] CND_POOL   = 4'd2;
   localparam logic [3:0] CND_CNT    = 4'd3;
   localparam logic [3:0] CND_GE     = 4'd4;
   localparam logic [3:0] CND_LT     = 4'd5;
   localparam logic [3:0] CND_STOP   = 4'd6;
   localparam logic [3:0] CND_IDLE   = 4'd7;
   localparam logic [3:0] CND_BUSY   = 4'd8;

   localparam int PC_W = 5;

   // program addresses that are jump targets
   localparam logic [PC_W-1:0] PC_WAIT  = 5'd0;
   localparam logic [PC_W-1:0] PC_CAPS  = 5'd1;
   localparam logic [PC_W-1:0] PC_INIT  = 5'd5;
   localparam logic [PC_W-1:0] PC_ROUND = 5'd6;
   localparam logic [PC_W-1:0] PC_SPARE = 5'd7;
   localparam logic [PC_W-1:0] PC_DIV   = 5'd9;
   localparam logic [PC_W-1:0] PC_GROW  = 5'd10;
   localparam logic [PC_W-1:0] PC_LEFT  = 5'd12;
   localparam logic [PC_W-1:0] PC_FULL  = 5'd14;
   localparam logic [PC_W-1:0] PC_MINC  = 5'd16;
   localparam logic [PC_W-1:0] PC_EMIT  = 5'd18;

   typedef struct packed {
      logic [3:0]      op;
      logic [3:0]      cnd;
      logic [PC_W-1:0] target;
      logic [1:0]      outc;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cnd: CND_ALWAYS, target: PC_WAIT, outc: OUT_FULL};
      case (pc)
         5'd0:  w = '{OP_WAIT,    CND_IDLE,   PC_WAIT,  OUT_FULL};
         5'd1:  w = '{OP_CAPSUM,  CND_POOL,   PC_CAPS,  OUT_FULL};
         5'd2:  w = '{OP_NOP,     CND_GE,     PC_FULL,  OUT_FULL};
         5'd3:  w = '{OP_MIN5,    CND_NONE,   PC_WAIT,  OUT_FULL};
         5'd4:  w = '{OP_NOP,     CND_LT,     PC_MINC,  OUT_FULL};
         5'd5:  w = '{OP_INIT,    CND_POOL,   PC_INIT,  OUT_FULL};
         5'd6:  w = '{OP_SPARE0,  CND_NONE,   PC_WAIT,  OUT_FULL};
         5'd7:  w = '{OP_SPARE,   CND_POOL,   PC_SPARE, OUT_FULL};
         5'd8:  w = '{OP_DIVINIT, CND_STOP,   PC_LEFT,  OUT_FULL};
         5'd9:  w = '{OP_DIV,     CND_CNT,    PC_DIV,   OUT_FULL};
         5'd10: w = '{OP_GROW,    CND_POOL,   PC_GROW,  OUT_FULL};
         5'd11: w = '{OP_NEXTRND, CND_ALWAYS, PC_ROUND, OUT_FULL};
         5'd12: w = '{OP_LEFT,    CND_POOL,   PC_LEFT,  OUT_FULL};
         5'd13: w = '{OP_SETOUT,  CND_ALWAYS, PC_EMIT,  OUT_SCALED};
         5'd14: w = '{OP_FULL,    CND_POOL,   PC_FULL,  OUT_FULL};
         5'd15: w = '{OP_STORE,   CND_ALWAYS, PC_EMIT,  OUT_FULL};
         5'd16: w = '{OP_INIT,    CND_POOL,   PC_MINC,  OUT_FULL};
         5'd17: w = '{OP_SETOUT,  CND_NONE,   PC_WAIT,  OUT_MIN};
         5'd18: w = '{OP_EMIT,    CND_BUSY,   PC_EMIT,  OUT_FULL};
         5'd19: w = '{OP_NOP,     CND_ALWAYS, PC_WAIT,  OUT_FULL};
         default: w = '{OP_NOP,   CND_ALWAYS, PC_WAIT,  OUT_FULL};
      endcase
      return w;
   endfunction

   // fixed pool weights 1,2,5,1,3
   function automatic logic [WT_W-1:0] pool_weight(input logic [POOL_W-1:0] p);
      logic [WT_W-1:0] w;
      case (p)
         3'd0:    w = 3'd1;
         3'd1:    w = 3'd2;
         3'd2:    w = 3'd5;
         3'd3:    w = 3'd1;
         3'd4:    w = 3'd3;
         default: w = 3'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/weighted_capped_share_allocator.sv */
// Top level of the weighted capped share allocator: microcoded sequencer and datapath.
// Depends on wcsa_pkg (constants, program table, pool weights).
`default_nettype none

// Usage
// req_ channel: one word carries a budget; the block splits it among five pools
// (core, engine, store, system, user). rsp_ channel: one word per budget with
// the five shares and an outcome code (full caps, scaled by weights, minimums).
// csr_ port: caps of the five pools (index 0..4) and the pool minimum (index 5),
// written by csr_we with no handshake; writes to index 6 or 7 are dropped.
// Write them only while no budget is in flight.
// Timing: one budget at a time; req_tready is high only while the sequencer
// sits at its wait step. A scaled split runs 1 to 8 sharing rounds, each
// dominated by the 2-bit-per-cycle divider and the pool walks that share
// one adder path. After the result is loaded the sequencer passes an idle
// step, then returns to its wait step and is ready again.
// A stalled result is held in the rsp_ register; the sequencer waits at its
// emit step until the register frees up, so nothing is dropped.
// Reset (synchronous, active high) restores the default caps and minimum,
// returns the sequencer to its wait step and clears rsp_tvalid.
module weighted_capped_share_allocator
   import wcsa_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [REQ_W-1:0]     req_tdata,   // budget
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // share_core, share_engine, share_store, share_system, share_user, outcome, zero pad
   output logic [RSP_W-1:0]     rsp_tdata,
   input  wire                  csr_we,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [SHARE_W-1:0]   csr_wdata
);

   // config registers
   logic [SHARE_W-1:0] cap_ff [POOLS];
   logic [SHARE_W-1:0] min_ff;

   // sequencer
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [POOL_W-1:0]  pool_ff, pool_in;
   ucode_type          uc;
   logic               cnd_hit;

   // datapath
   logic [BUDGET_W-1:0] bud_ff, bud_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SHARE_W-1:0]  sh_ff [POOLS];
   logic [SHARE_W-1:0]  sh_in [POOLS];
   logic [TW_W-1:0]     tw_ff, tw_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [TW_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic [BUDGET_W-1:0] st_ff, st_in;
   logic [1:0]          outc_ff, outc_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                req_fire, out_busy, open;
   logic [SHARE_W-1:0]  cap_sel, sh_sel, gap, give, sh_grow;
   logic [WT_W-1:0]     wt;
   logic [PROD_W-1:0]   prod;
   logic [GROW_W-1:0]   grown;
   logic [TW_W+1:0]     dv_t, dv_d1, dv_d2, dv_d3;
   logic [BUDGET_W-1:0] store_out;

   assign uc         = ucode_rom(pc_ff);
   assign req_tready = (pc_ff == PC_WAIT);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   assign cap_sel = cap_ff[pool_ff];
   assign sh_sel  = sh_ff[pool_ff];
   assign wt      = pool_weight(pool_ff);
   assign open    = (sh_sel < cap_sel);

   // one round of sharing: grow an open pool by weight * quota, then clip at cap
   assign prod    = PROD_W'(wt) * PROD_W'(quo_ff);
   assign grown   = GROW_W'(sh_sel) + (open ? GROW_W'(prod) : GROW_W'(0));
   assign sh_grow = (grown > GROW_W'(cap_sel)) ? cap_sel : grown[SHARE_W-1:0];

   // leftover pass: fill toward cap in pool order
   assign gap  = cap_sel - sh_sel;
   assign give = (ACC_W'(gap) > acc_ff) ? acc_ff[SHARE_W-1:0] : gap;

   // radix-4 restoring division step, divisor is the open weight
   assign dv_t  = {rem_ff, quo_ff[QUO_W-1 -: 2]};
   assign dv_d1 = (TW_W+2)'(tw_ff);
   assign dv_d2 = (TW_W+2)'(tw_ff) << 1;
   assign dv_d3 = dv_d1 + dv_d2;

   assign store_out = (outc_ff == OUT_FULL) ? st_ff : BUDGET_W'(sh_ff[STORE_POOL]);

   always_comb begin
      case (uc.cnd)
         CND_NONE:   cnd_hit = 1'b0;
         CND_ALWAYS: cnd_hit = 1'b1;
         CND_POOL:   cnd_hit = (pool_ff != POOL_W'(LAST_POOL));
         CND_CNT:    cnd_hit = (cnt_ff != CNT_W'(DIV_STEPS - 1));
         CND_GE:     cnd_hit = (bud_ff >= BUDGET_W'(acc_ff));
         CND_LT:     cnd_hit = (bud_ff < BUDGET_W'(acc_ff));
         // stop after a round once the remainder fits in the open weight, or once MAX_ROUNDS rounds have run
         CND_STOP:   cnd_hit = ((rnd_ff != '0) && (acc_ff <= ACC_W'(tw_ff)))
                               || (rnd_ff == RND_W'(MAX_ROUNDS));
         CND_IDLE:   cnd_hit = !req_fire;
         CND_BUSY:   cnd_hit = out_busy;
         default:    cnd_hit = 1'b1;
      endcase
      pc_in = cnd_hit ? uc.target : pc_ff + PC_W'(1);

      pool_in = pool_ff;
      if (uc.cnd == CND_POOL) begin
         pool_in = (pool_ff == POOL_W'(LAST_POOL)) ? '0 : pool_ff + POOL_W'(1);
      end
   end

   always_comb begin
      bud_in       = bud_ff;
      acc_in       = acc_ff;
      sh_in        = sh_ff;
      tw_in        = tw_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      st_in        = st_ff;
      outc_in      = outc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (uc.op)
         OP_WAIT: begin
            if (req_fire) begin
               bud_in = req_tdata[BUDGET_W-1:0];
               acc_in = '0;
            end
         end
         OP_CAPSUM: acc_in = acc_ff + ACC_W'(cap_sel);
         OP_MIN5:   acc_in = (ACC_W'(min_ff) << 2) + ACC_W'(min_ff);
         OP_INIT: begin
            sh_in[pool_ff] = min_ff;
            rnd_in         = '0;
         end
         OP_SPARE0: begin
            acc_in = bud_ff[ACC_W-1:0];
            tw_in  = '0;
         end
         OP_SPARE: begin
            acc_in = acc_ff - ACC_W'(sh_sel);
            if (open) begin
               tw_in = tw_ff + TW_W'(wt);
            end
         end
         OP_DIVINIT: begin
            quo_in = QUO_W'(acc_ff);
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (dv_t >= dv_d3) begin
               rem_in = TW_W'(dv_t - dv_d3);
               quo_in = {quo_ff[QUO_W-3:0], 2'd3};
            end else if (dv_t >= dv_d2) begin
               rem_in = TW_W'(dv_t - dv_d2);
               quo_in = {quo_ff[QUO_W-3:0], 2'd2};
            end else if (dv_t >= dv_d1) begin
               rem_in = TW_W'(dv_t - dv_d1);
               quo_in = {quo_ff[QUO_W-3:0], 2'd1};
            end else begin
               rem_in = TW_W'(dv_t);
               quo_in = {quo_ff[QUO_W-3:0], 2'd0};
            end
         end
         OP_GROW:    sh_in[pool_ff] = sh_grow;
         OP_NEXTRND: rnd_in = rnd_ff + RND_W'(1);
         OP_LEFT: begin
            if ((acc_ff != '0) && open) begin
               sh_in[pool_ff] = sh_sel + give;
               acc_in         = acc_ff - ACC_W'(give);
            end
         end
         OP_SETOUT: outc_in = uc.outc;
         OP_FULL:   sh_in[pool_ff] = cap_sel;
         OP_STORE: begin
            // budget minus the other four caps, store pool is uncapped here
            st_in   = bud_ff - BUDGET_W'(acc_ff) + BUDGET_W'(cap_ff[STORE_POOL]);
            outc_in = uc.outc;
         end
         OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {outc_ff, sh_ff[4], sh_ff[3], store_out, sh_ff[1], sh_ff[0]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff[0]    <= RST_CAP_CORE;
         cap_ff[1]    <= RST_CAP_ENGINE;
         cap_ff[2]    <= RST_CAP_STORE;
         cap_ff[3]    <= RST_CAP_SYSTEM;
         cap_ff[4]    <= RST_CAP_USER;
         min_ff       <= RST_POOL_MIN;
      end else begin
         pc_ff        <= pc_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CAP_CORE:   cap_ff[0] <= csr_wdata;
               CSR_CAP_ENGINE: cap_ff[1] <= csr_wdata;
               CSR_CAP_STORE:  cap_ff[2] <= csr_wdata;
               CSR_CAP_SYSTEM: cap_ff[3] <= csr_wdata;
               CSR_CAP_USER:   cap_ff[4] <= csr_wdata;
               CSR_POOL_MIN:   min_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bud_ff      <= bud_in;
      acc_ff      <= acc_in;
      sh_ff       <= sh_in;
      tw_ff       <= tw_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rnd_ff      <= rnd_in;
      st_ff       <= st_in;
      outc_ff     <= outc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* rtl/core/wcsa_checker.sv */
// Port-level assertions (wcsa_port_checks) for weighted_capped_share_allocator, bound to it.
// Depends on wcsa_pkg for field positions and outcome codes.
`default_nettype none

module wcsa_port_checks
   import wcsa_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_tvalid,
   input wire                 req_tready,
   input wire                 rsp_tvalid,
   input wire                 rsp_tready,
   input wire [RSP_W-1:0]     rsp_tdata
);

   logic [1:0]         outc;
   logic [SHARE_W-1:0] core, engine, system, user;
   logic [BUDGET_W-1:0] store;

   assign outc   = rsp_tdata[F_OUTC +: 2];
   assign core   = rsp_tdata[F_CORE +: SHARE_W];
   assign engine = rsp_tdata[F_ENGINE +: SHARE_W];
   assign store  = rsp_tdata[F_STORE +: BUDGET_W];
   assign system = rsp_tdata[F_SYSTEM +: SHARE_W];
   assign user   = rsp_tdata[F_USER +: SHARE_W];

   // a stalled word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // one budget at a time: the block is busy right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // minimum case hands every pool the same share
   a_min_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (outc == OUT_MIN) |->
         (core == engine) && (core == system) && (core == user)
         && (store == BUDGET_W'(core)))
      else $error("minimum case shares differ");

   // only the full case lets the store share exceed a register width
   a_store_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (outc != OUT_FULL) |-> (store >> SHARE_W) == '0)
      else $error("store share too wide outside full case");

   // reset leaves no word on the result side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind weighted_capped_share_allocator wcsa_port_checks u_wcsa_port_checks (.*);

`default_nettype wire

/* sim/wcsa_checker.sv */
// Checker for the weighted capped share allocator: watches the csr_, req_ and rsp_ ports,
// predicts each split from its own copy of the caps and minimum, and compares field by field.
// Depends on wcsa_pkg for widths, field offsets, register indexes and outcome codes.

module wcsa_checker
   import wcsa_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tready,
   input  wire  [REQ_W-1:0]     req_tdata,
   input  wire                  rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire  [RSP_W-1:0]     rsp_tdata,
   input  wire                  csr_we,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [SHARE_W-1:0]   csr_wdata,
   output int                   mismatches,
   output int                   pending,
   output int                   results_seen,
   output int                   full_count,
   output int                   scaled_count,
   output int                   min_count
);

   typedef struct packed {
      logic [SHARE_W-1:0]  core;
      logic [SHARE_W-1:0]  engine;
      logic [BUDGET_W-1:0] store;
      logic [SHARE_W-1:0]  system;
      logic [SHARE_W-1:0]  user;
      logic [1:0]          outcome;
   } split_type;

   // weights of pools 4 down to 0
   localparam logic [POOLS-1:0][3:0] WEIGHTS = {4'd3, 4'd1, 4'd5, 4'd2, 4'd1};

   logic [POOLS-1:0][SHARE_W-1:0] cap_set;
   logic [SHARE_W-1:0]            floor_set;
   split_type                     pending_splits[$];

   function automatic logic [63:0] weight_open(input logic [POOLS-1:0][63:0] share);
      logic [63:0] w;
      w = 0;
      for (int p = 0; p < POOLS; p++)
         if (share[p] < 64'(cap_set[p])) w += 64'(WEIGHTS[p]);
      return w;
   endfunction

   function automatic logic [63:0] shares_total(input logic [POOLS-1:0][63:0] share);
      logic [63:0] s;
      s = 0;
      for (int p = 0; p < POOLS; p++) s += share[p];
      return s;
   endfunction

   function automatic split_type predict_split(input logic [63:0] budget);
      logic [POOLS-1:0][63:0] share;
      logic [63:0] cap_sum, rest, open_w, quota, spare, give, grown;
      bit settled;
      split_type res;
      cap_sum = 0;
      for (int p = 0; p < POOLS; p++) cap_sum += 64'(cap_set[p]);
      if (budget >= cap_sum) begin
         for (int p = 0; p < POOLS; p++) share[p] = 64'(cap_set[p]);
         // store takes everything the other four caps leave
         share[STORE_POOL] = budget - (cap_sum - 64'(cap_set[STORE_POOL]));
         res.outcome = OUT_FULL;
      end else if (budget < 64'(POOLS) * 64'(floor_set)) begin
         for (int p = 0; p < POOLS; p++) share[p] = 64'(floor_set);
         res.outcome = OUT_MIN;
      end else begin
         for (int p = 0; p < POOLS; p++) share[p] = 64'(floor_set);
         open_w = weight_open(share);
         rest = 0;
         settled = 1'b0;
         for (int r = 0; r < MAX_ROUNDS && !settled; r++) begin
            spare = budget - shares_total(share);
            quota = (open_w != 0) ? spare / open_w : 64'd0;
            for (int p = 0; p < POOLS; p++) begin
               grown = share[p];
               if (share[p] < 64'(cap_set[p])) grown += 64'(WEIGHTS[p]) * quota;
               share[p] = (grown > 64'(cap_set[p])) ? 64'(cap_set[p]) : grown;
            end
            rest = budget - shares_total(share);
            open_w = weight_open(share);
            settled = !(rest > open_w);
         end
         // leftover goes out in pool order up to each cap
         for (int p = 0; p < POOLS; p++) begin
            if (rest != 0 && share[p] < 64'(cap_set[p])) begin
               give = 64'(cap_set[p]) - share[p];
               if (give > rest) give = rest;
               share[p] += give;
               rest -= give;
            end
         end
         res.outcome = OUT_SCALED;
      end
      res.core   = share[0][SHARE_W-1:0];
      res.engine = share[1][SHARE_W-1:0];
      res.store  = share[STORE_POOL][BUDGET_W-1:0];
      res.system = share[3][SHARE_W-1:0];
      res.user   = share[4][SHARE_W-1:0];
      return res;
   endfunction

   function automatic int field_bad(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      split_type want, got;
      int bad;
      if (reset) begin
         cap_set   <= {RST_CAP_USER, RST_CAP_SYSTEM, RST_CAP_STORE, RST_CAP_ENGINE,
                       RST_CAP_CORE};
         floor_set <= RST_POOL_MIN;
         pending_splits.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CAP_CORE, CSR_CAP_ENGINE, CSR_CAP_STORE, CSR_CAP_SYSTEM, CSR_CAP_USER:
                  cap_set[csr_index] <= csr_wdata;
               CSR_POOL_MIN: floor_set <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_splits.push_back(predict_split(64'(req_tdata[BUDGET_W-1:0])));
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (pending_splits.size() == 0) begin
               $error("split word arrived with no budget outstanding");
               mismatches <= mismatches + 1;
            end else begin
               want = pending_splits.pop_front();
               got.core    = rsp_tdata[F_CORE +: SHARE_W];
               got.engine  = rsp_tdata[F_ENGINE +: SHARE_W];
               got.store   = rsp_tdata[F_STORE +: BUDGET_W];
               got.system  = rsp_tdata[F_SYSTEM +: SHARE_W];
               got.user    = rsp_tdata[F_USER +: SHARE_W];
               got.outcome = rsp_tdata[F_OUTC +: 2];
               bad = field_bad("share_core", want.core, got.core)
                   + field_bad("share_engine", want.engine, got.engine)
                   + field_bad("share_store", want.store, got.store)
                   + field_bad("share_system", want.system, got.system)
                   + field_bad("share_user", want.user, got.user)
                   + field_bad("outcome", want.outcome, got.outcome);
               mismatches <= mismatches + bad;
               case (want.outcome)
                  OUT_FULL:   full_count <= full_count + 1;
                  OUT_SCALED: scaled_count <= scaled_count + 1;
                  default:    min_count <= min_count + 1;
               endcase
            end
         end
      end
      pending <= pending_splits.size();
   end

endmodule

/* sim/tb_weighted_capped_share_allocator.sv */
// Top of the allocator testbench: clock, reset, register programming and budget stimulus.
// Instantiates weighted_capped_share_allocator beside wcsa_checker; uses wcsa_pkg.

module tb_weighted_capped_share_allocator;
   import wcsa_pkg::*;

   typedef logic [POOLS-1:0][SHARE_W-1:0] cap_list_type;

   // index 6 and 7 exist on the port but hold no register
   localparam logic [CSR_IDX_W-1:0] CSR_VOID_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VOID_HI = 3'd7;
   localparam logic [SHARE_W-1:0]   REG_MAX     = '1;
   // worst case: 970 budgets x (longest scaled split + long stalls and gaps), several times over
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 79;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;   // budget
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // share_core, share_engine, share_store, share_system, share_user, outcome, zero pad
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SHARE_W-1:0]   csr_wdata;

   int mismatches, pending, results_seen, full_count, scaled_count, min_count;

   // stimulus bookkeeping
   int          words_sent;
   int          settings_used;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int unsigned cycle_count;
   cap_list_type       caps_now;
   logic [SHARE_W-1:0] floor_now;

   weighted_capped_share_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   wcsa_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen),
      .full_count   (full_count),
      .scaled_count (scaled_count),
      .min_count    (min_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost split word ends up here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: stalls per cycle with the current phase's odds. With zero odds
   // tready just sits high, giving long stretches of back-to-back acceptance.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic cap_list_type cap_list(input logic [SHARE_W-1:0] core, engine, store,
                                             system, user);
      return {user, system, store, engine, core};
   endfunction

   // Caps spread over tiny, mid-size, huge and the two extremes so that pools
   // clip in different rounds and the minimum lands above some caps.
   function automatic logic [SHARE_W-1:0] random_cap();
      case ($urandom_range(9))
         0:       return '0;
         1:       return REG_MAX;
         2, 3, 4: return SHARE_W'($urandom_range(1, 64));
         5, 6, 7: return SHARE_W'($urandom_range(65, 8000));
         default: return SHARE_W'($urandom());
      endcase
   endfunction

   function automatic logic [SHARE_W-1:0] random_floor();
      case ($urandom_range(9))
         0, 1, 2:    return SHARE_W'($urandom_range(0, 40));
         3, 4, 5, 6: return SHARE_W'($urandom_range(41, 1500));
         7:          return '0;
         8:          return SHARE_W'($urandom());
         default:    return REG_MAX;
      endcase
   endfunction

   // Budgets aimed mostly at the scaled window [5*minimum, sum of caps), where
   // the sharing rounds run; the rest hit the minimum and full cases, the
   // boundaries between them, and the whole 32-bit range.
   function automatic logic [BUDGET_W-1:0] pick_budget();
      logic [63:0] cap_sum, floor5;
      int pick;
      cap_sum = 0;
      for (int p = 0; p < POOLS; p++) cap_sum += 64'(caps_now[p]);
      floor5 = 64'(POOLS) * 64'(floor_now);
      pick = $urandom_range(99);
      if (pick < 60 && floor5 < cap_sum)
         return BUDGET_W'(floor5 + 64'($urandom_range(0, 32'(cap_sum - floor5 - 1))));
      if (pick < 72 && floor5 > 0)
         return BUDGET_W'($urandom_range(0, 32'(floor5 - 1)));
      if (pick < 84)
         return BUDGET_W'(cap_sum + 64'($urandom_range(0, 4096)));
      if (pick < 92) begin
         case ($urandom_range(3))
            0:       return BUDGET_W'(cap_sum - 1);
            1:       return BUDGET_W'(cap_sum);
            2:       return BUDGET_W'(floor5 - 1);
            default: return BUDGET_W'(floor5);
         endcase
      end
      return BUDGET_W'($urandom());
   endfunction

   // One register word per cycle; csr_we stays high across the burst.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [SHARE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Writes all six registers, with junk to the unused indexes in between so
   // an aliasing decode would clobber a live register.
   task automatic program_regs(input cap_list_type caps, input logic [SHARE_W-1:0] floor_val);
      csr_put(CSR_CAP_CORE, caps[0]);
      csr_put(CSR_CAP_ENGINE, caps[1]);
      csr_put(CSR_VOID_LO, SHARE_W'($urandom()));
      csr_put(CSR_CAP_STORE, caps[2]);
      csr_put(CSR_CAP_SYSTEM, caps[3]);
      csr_put(CSR_VOID_HI, SHARE_W'($urandom()));
      csr_put(CSR_CAP_USER, caps[4]);
      csr_put(CSR_POOL_MIN, floor_val);
      csr_we    <= 1'b0;
      caps_now  = caps;
      floor_now = floor_val;
      settings_used++;
   endtask

   // Sender: random idle cycles before the word, then hold it until accepted.
   // tvalid is only dropped when a gap really follows.
   task automatic send_budget(input logic [BUDGET_W-1:0] budget);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(budget);
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Block is idle once every split word for the budgets sent has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_seen < words_sent) @(posedge clock);
   endtask

   initial begin
      reset              <= 1'b1;
      req_tvalid         <= 1'b0;
      req_tdata          <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_CAP_CORE;
      csr_wdata          <= '0;
      words_sent         = 0;
      settings_used      = 1;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      caps_now  = {RST_CAP_USER, RST_CAP_SYSTEM, RST_CAP_STORE, RST_CAP_ENGINE, RST_CAP_CORE};
      floor_now = RST_POOL_MIN;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: caps sum to 99000, five minimums are 2500.
      send_budget(0);
      send_budget(2499);
      send_budget(2500);
      send_budget(2501);
      send_budget(40000);
      send_budget(98999);
      send_budget(99000);
      send_budget(99001);
      send_budget(32'h8000_0000);
      send_budget(32'hFFFF_FFFF);
      drain();

      // Minimum above several caps: those pools clip down in the first round.
      program_regs(cap_list(100, 3000, 50, 200, 8000), 300);
      send_budget(1500);
      send_budget(5000);
      send_budget(11349);
      drain();

      // Five minimums exceed the cap sum: full case is decided first.
      program_regs(cap_list(10, 10, 10, 10, 10), 1000);
      send_budget(20);
      send_budget(50);
      send_budget(4999);
      drain();

      // All zero: every budget is a full case, store takes it whole.
      program_regs(cap_list(0, 0, 0, 0, 0), 0);
      send_budget(0);
      send_budget(32'h5A5A_5A5A);
      drain();

      // All registers at their maximum.
      program_regs(cap_list(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX), REG_MAX);
      send_budget(0);
      send_budget(32'd5242874);
      send_budget(32'd5242875);
      send_budget(32'hFFFF_FFFF);
      drain();

      // Random phases: new register setting each time, idle pattern rotates
      // through none / sender-heavy / receiver-heavy / both light.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            3:  program_regs(cap_list(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX), '0);
            7:  program_regs(cap_list(0, 0, 0, 0, 0), REG_MAX);
            11: program_regs(cap_list(RST_CAP_CORE, RST_CAP_ENGINE, RST_CAP_STORE,
                                      RST_CAP_SYSTEM, RST_CAP_USER), RST_POOL_MIN);
            default: program_regs(cap_list(random_cap(), random_cap(), random_cap(),
                                           random_cap(), random_cap()), random_floor());
         endcase
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++) send_budget(pick_budget());
         drain();
      end

      // wait out longer than the longest scaled split; let anything stray show up
      repeat (300) @(posedge clock);

      $display("Covered %0d budgets over %0d register settings and four idle patterns",
               words_sent, settings_used);
      $display("Split words checked: %0d full-cap, %0d scaled, %0d minimum; %0d mismatches",
               full_count, scaled_count, min_count, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
